FILE: design/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and the rotate helper for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } core_state_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned r);
    rotr = (v >> r) | (v << (32 - r));
  endfunction

endpackage

FILE: design/sha_item_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_item_fifo
// Front end: accepts input transactions, drops empty ones, queues the rest.
// ----------------------------------------------------------------------------
module sha_item_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  sha_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_take,
  output sha_pkg::item_t q_item
);
  import sha_pkg::*;

  item_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     cnt_r;
  logic             wr, rd, useful;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];
  // items with neither byte nor end do nothing, so they are not queued
  assign useful  = in_item.byte_present | in_item.end_of_message;
  assign wr      = push & ~full & useful;
  assign rd      = q_take & q_valid;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end

endmodule

FILE: design/sha_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_core
// Back end: block buffer, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_take,
  input  sha_pkg::item_t q_item,
  output logic           empty,
  input  logic           pop,
  output logic [31:0]    digest_word,
  output logic [2:0]     word_index,
  output logic           last_word
);
  import sha_pkg::*;

  core_state_t state_r, state_nxt;
  logic [31:0] blk_r [16];  // block buffer, big-endian bytes in each word
  logic [6:0]  fill_r;
  logic [63:0] bits_r;
  logic [31:0] h_r [8];
  logic [31:0] a_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  t_r;
  logic [2:0]  oi_r;
  logic        fin_r;     // finishing message
  logic        second_r;  // length still needs its own block
  logic        pend_r;    // end flag of current item still to process

  logic [31:0] pad_blk [16];
  logic [31:0] wt, s0, s1, big0, big1, ch, maj, t1, t2, wnew;

  assign empty       = (state_r != ST_OUT);
  assign digest_word = h_r[oi_r];
  assign word_index  = oi_r;
  assign last_word   = (oi_r == 3'd7);
  assign q_take      = (state_r == ST_IDLE) & q_valid;

  always_comb begin
    s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    wt   = w_r[0];
    big1 = rotr(a_r[4], 6) ^ rotr(a_r[4], 11) ^ rotr(a_r[4], 25);
    ch   = (a_r[4] & a_r[5]) ^ (~a_r[4] & a_r[6]);
    t1   = a_r[7] + big1 + ch + ROUND_K[t_r] + wt;
    big0 = rotr(a_r[0], 2) ^ rotr(a_r[0], 13) ^ rotr(a_r[0], 22);
    maj  = (a_r[0] & a_r[1]) ^ (a_r[0] & a_r[2]) ^ (a_r[1] & a_r[2]);
    t2   = big0 + maj;
  end

  // padded block: 0x80 at the fill point, zeros after, length if it fits
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (i >= 56 && fill_r <= 7'd55)
        pad_blk[i/4][8*(3-i%4) +: 8] = bits_r[8*(63-i) +: 8];
      else if (i == int'(fill_r))
        pad_blk[i/4][8*(3-i%4) +: 8] = 8'h80;
      else if (i > int'(fill_r))
        pad_blk[i/4][8*(3-i%4) +: 8] = 8'h00;
      else
        pad_blk[i/4][8*(3-i%4) +: 8] = blk_r[i/4][8*(3-i%4) +: 8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_PAD;
      ST_PAD: begin
        if (fill_r == 7'd64) state_nxt = ST_ROUND;
        else if (pend_r || second_r) state_nxt = ST_PAD;
        else if (fin_r) state_nxt = ST_OUT;
        else state_nxt = ST_IDLE;
      end
      ST_ROUND: if (t_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD:  state_nxt = ST_PAD;
      ST_OUT:   if (pop && oi_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ST_PAD is the dispatch step: decides whether to compress, pad, finish or return to idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      bits_r   <= '0;
      t_r      <= '0;
      oi_r     <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      pend_r   <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[i];
    end else begin
      case (state_r)
        ST_IDLE: if (q_valid) begin
          pend_r <= q_item.end_of_message;
          if (q_item.byte_present) begin
            blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= q_item.data_byte;
            fill_r <= fill_r + 7'd1;
            bits_r <= bits_r + 64'd8;
          end
        end
        ST_PAD: begin
          if (fill_r == 7'd64) begin
            for (int i = 0; i < 16; i++) w_r[i] <= blk_r[i];
            for (int i = 0; i < 8; i++) a_r[i] <= h_r[i];
            fill_r <= '0;
            t_r    <= '0;
          end else if (pend_r) begin
            pend_r <= 1'b0;
            for (int i = 0; i < 16; i++) blk_r[i] <= pad_blk[i];
            if (fill_r <= 7'd55) fin_r <= 1'b1;
            else second_r <= 1'b1;
            fill_r <= 7'd64;
          end else if (second_r) begin
            second_r <= 1'b0;
            for (int i = 0; i < 14; i++) blk_r[i] <= '0;
            blk_r[14] <= bits_r[63:32];
            blk_r[15] <= bits_r[31:0];
            fin_r  <= 1'b1;
            fill_r <= 7'd64;
          end else if (fin_r) begin
            fin_r <= 1'b0;
            oi_r  <= '0;
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          a_r[1] <= a_r[0];
          a_r[2] <= a_r[1];
          a_r[3] <= a_r[2];
          a_r[4] <= a_r[3] + t1;
          a_r[5] <= a_r[4];
          a_r[6] <= a_r[5];
          a_r[7] <= a_r[6];
          a_r[0] <= t1 + t2;
          t_r    <= t_r + 6'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + a_r[i];
        end
        ST_OUT: if (pop) begin
          oi_r <= oi_r + 3'd1;
          if (oi_r == 3'd7) begin
            for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[i];
            bits_r <= '0;
            fill_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one byte per input transaction.
//
// Input: push/full with in_data_byte, in_byte_present, in_end_of_message.
// A four-entry queue holds transactions while the core is busy.
// Output: empty/pop; each finished message yields eight transactions,
// digest words 0..7, with out_last_word on the eighth.
// Each byte passes through the idle and dispatch states of the core; a full
// 64-byte block then runs 64 rounds on the one shared round unit, a fold and
// a dispatch. End of message adds one or two padded blocks; words wait for pop.
// A stalled receiver holds the core; the queue keeps taking input until full.
// Reset (rst_n low, synchronous) loads the initial hash values and clears
// the byte count, bit length and queue.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_take;

  assign in_item = '{data_byte: in_data_byte, byte_present: in_byte_present,
                     end_of_message: in_end_of_message};

  sha_item_fifo u_fifo (
    .clk, .rst_n, .push, .full, .in_item,
    .q_valid, .q_take, .q_item
  );

  sha_core u_core (
    .clk, .rst_n, .q_valid, .q_take, .q_item, .empty, .pop,
    .digest_word(out_digest_word), .word_index(out_word_index),
    .last_word(out_last_word)
  );

endmodule
